// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the fragment shader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising i_clk edge, off while reset is held.
`define TZB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define TZB_ASSERT_NEXT(lbl, pre, post, msg) \
    `TZB_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== hw/rtl/tzb_pkg.sv =====
// ----------------------------------------------------------------------------
// tzb_pkg
// Shared types and constants of the triangle z-buffer fragment shader.
// ----------------------------------------------------------------------------
`default_nettype none

package tzb_pkg;

    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 256;
    localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(CELLS);

    // pixel to Q1.14: x * 32768 / W, exact for power-of-two screen sizes
    localparam int PX_SCALE = 32768 / SCREEN_WIDTH;
    localparam int PY_SCALE = 32768 / SCREEN_HEIGHT;

    localparam int NUM_VERT = 3;
    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 9;
    localparam int OP_W     = 18;   // multiplier operand width
    localparam int WHALF_W  = 17;   // weight is split in two halves of this width
    localparam int AREA_W   = 34;   // |cross product| of 17-bit differences
    localparam int ACC_W    = 56;   // accumulator and divider width
    localparam int ZQ_W     = 17;   // stored depth, Q2.14
    localparam int ZDIV_N   = 15;   // quotient bits of the depth divide
    localparam int CDIV_N   = 8;    // quotient bits of the color divide
    localparam int Z_SHIFT  = 14;
    localparam int C_SHIFT  = 8;

    localparam logic signed [ZQ_W-1:0] FAR_DEPTH = 17'sd32768;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SHADE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type                   req_type;
        logic [1:0]                  vertex_slot;
        logic signed [COORD_W-1:0]   vert_x;
        logic signed [COORD_W-1:0]   vert_y;
        logic signed [COORD_W-1:0]   vert_z;
        logic [COLOR_W-1:0]          vert_red;
        logic [COLOR_W-1:0]          vert_green;
        logic [COLOR_W-1:0]          vert_blue;
        logic signed [7:0]           pixel_x;
        logic signed [7:0]           pixel_y;
    } t_req;

    typedef struct packed {
        logic                        drawn;
        logic [7:0]                  pix_red;
        logic [7:0]                  pix_green;
        logic [7:0]                  pix_blue;
        logic signed [COORD_W-1:0]   frag_depth;
    } t_res;

endpackage

`default_nettype wire

// ===== hw/rtl/tzb_if.sv =====
// ----------------------------------------------------------------------------
// tzb_if
// Valid/ready channels for requests and results of the fragment shader.
// ----------------------------------------------------------------------------
`default_nettype none

interface tzb_req_if import tzb_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tzb_res_if import tzb_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tzb_ram.sv =====
// ----------------------------------------------------------------------------
// tzb_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tzb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_zbuffer_fragment_shader.sv =====
// ----------------------------------------------------------------------------
// triangle_zbuffer_fragment_shader
// Barycentric triangle coverage, depth/color interpolation and z-buffer test.
// ----------------------------------------------------------------------------
// Usage:
//   i_req (sink) takes requests: load vertex, shade pixel or clear depth store.
//   o_res (source) returns one result per shade request, none otherwise.
//   One request at a time: i_req.ready is high only while the sequencer idles.
//   Steps per request (accept to next ready):
//     load vertex  two multiply-accumulates for the area, one latch
//     shade pixel  full path: edge, depth MAC, check, depth divide,
//                  fix/compare, MAC, check and divide per color, result;
//                  straight to the result when off screen or degenerate,
//                  after the edge step when the pixel is outside the triangle
//     clear        one depth store entry per cycle
//   Cross products and weighted sums use one 18x18 signed multiply-accumulate
//   unit and all quotients one restoring divider, one quotient bit a cycle.
//   Reset: vertices and area go to zero, then a clear pass writes far
//   (2.0) into every depth store entry; ready stays low until it ends.
//   Receiver stall: the result waits in the output register while the next
//   request is accepted; a following shade holds in its last step until the
//   output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module triangle_zbuffer_fragment_shader import tzb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tzb_req_if.sink   i_req,
    tzb_res_if.source o_res
);

    typedef enum logic [12:0] {
        ST_CLEAR = 13'b0000000000001,
        ST_IDLE  = 13'b0000000000010,
        ST_AREA  = 13'b0000000000100,
        ST_EDGE  = 13'b0000000001000,
        ST_ZMAC  = 13'b0000000010000,
        ST_ZCHK  = 13'b0000000100000,
        ST_ZDIV  = 13'b0000001000000,
        ST_ZFIX  = 13'b0000010000000,
        ST_ZCMP  = 13'b0000100000000,
        ST_CMAC  = 13'b0001000000000,
        ST_CCHK  = 13'b0010000000000,
        ST_CDIV  = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } t_state;

    localparam logic signed [10:0] X_HALF = 11'(SCREEN_WIDTH / 2);
    localparam logic signed [10:0] Y_HALF = 11'(SCREEN_HEIGHT / 2);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(CELLS - 1);

    // control state
    t_state                    r_state, n_state;
    logic [1:0]                r_k, n_k;          // vertex / edge index
    logic [1:0]                r_ph, n_ph;        // phase within a step group
    logic [1:0]                r_col, n_col;      // color channel
    logic [3:0]                r_dcnt, n_dcnt;    // divide step count
    logic [ADDR_W-1:0]         r_clr_addr, n_clr_addr;
    logic                      r_out_valid, n_out_valid;
    logic                      r_cov_fail, n_cov_fail;

    // triangle state
    logic signed [COORD_W-1:0] r_vx [NUM_VERT], n_vx [NUM_VERT];
    logic signed [COORD_W-1:0] r_vy [NUM_VERT], n_vy [NUM_VERT];
    logic signed [COORD_W-1:0] r_vz [NUM_VERT], n_vz [NUM_VERT];
    logic [COLOR_W-1:0]        r_cr [NUM_VERT], n_cr [NUM_VERT];
    logic [COLOR_W-1:0]        r_cg [NUM_VERT], n_cg [NUM_VERT];
    logic [COLOR_W-1:0]        r_cb [NUM_VERT], n_cb [NUM_VERT];
    logic [AREA_W-1:0]         r_area, n_area;
    logic                      r_area_neg, n_area_neg;

    // per-pixel datapath
    logic signed [COORD_W-1:0] r_px, n_px;
    logic signed [COORD_W-1:0] r_py, n_py;
    logic [ADDR_W-1:0]         r_addr, n_addr;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic [AREA_W-1:0]         r_w [NUM_VERT], n_w [NUM_VERT];
    logic [ACC_W-1:0]          r_rem, n_rem;
    logic [ACC_W-1:0]          r_dvs, n_dvs;
    logic [ZDIV_N-1:0]         r_quo, n_quo;
    logic                      r_zneg, n_zneg;
    logic signed [ZQ_W-1:0]    r_zq, n_zq;
    logic [7:0]                r_red, n_red;
    logic [7:0]                r_green, n_green;
    logic [7:0]                r_blue, n_blue;
    logic                      r_drawn, n_drawn;
    t_res                      r_out, n_out;

    // depth store port
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [ZQ_W-1:0]           ram_wdata;
    logic [ZQ_W-1:0]           ram_rdata;

    // shared multiply-accumulate unit
    logic signed [OP_W-1:0]    mac_a, mac_b;
    logic                      mac_first, mac_sub, mac_hi;
    logic signed [2*OP_W-1:0]  mac_prod;
    logic signed [ACC_W-1:0]   mac_term, mac_sum;

    // shared divider step
    logic                      div_ge;
    logic [ACC_W-1:0]          div_diff;

    logic                      accept;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    function automatic logic [1:0] nxt3(input logic [1:0] k);
        return (k == 2'd2) ? 2'd0 : k + 2'd1;
    endfunction

    tzb_ram #(
        .WIDTH (ZQ_W),
        .DEPTH (CELLS)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // MAC operand selection. Cross product cross(o,q,r) =
    // (qx-ox)*(ry-oy) - (qy-oy)*(rx-ox), one term per phase.
    // ------------------------------------------------------------------
    always_comb begin
        logic [1:0]                o_i, q_i;
        logic signed [COORD_W-1:0] rx, ry;
        logic signed [COORD_W:0]   d_a, d_b;
        logic [AREA_W-1:0]         wsel;
        logic [COLOR_W-1:0]        csel;

        o_i = (r_state == ST_AREA) ? 2'd0 : nxt3(r_k);
        q_i = (r_state == ST_AREA) ? 2'd1 : nxt3(nxt3(r_k));
        rx  = (r_state == ST_AREA) ? r_vx[2] : r_px;
        ry  = (r_state == ST_AREA) ? r_vy[2] : r_py;
        wsel = r_w[r_k];

        unique case (r_col)
            2'd0:    csel = r_cr[r_k];
            2'd1:    csel = r_cg[r_k];
            2'd2:    csel = r_cb[r_k];
            default: csel = '0;
        endcase

        if (r_ph == 2'd0) begin
            d_a = {r_vx[q_i][COORD_W-1], r_vx[q_i]} - {r_vx[o_i][COORD_W-1], r_vx[o_i]};
            d_b = {ry[COORD_W-1], ry} - {r_vy[o_i][COORD_W-1], r_vy[o_i]};
        end else begin
            d_a = {r_vy[q_i][COORD_W-1], r_vy[q_i]} - {r_vy[o_i][COORD_W-1], r_vy[o_i]};
            d_b = {rx[COORD_W-1], rx} - {r_vx[o_i][COORD_W-1], r_vx[o_i]};
        end

        if (r_state == ST_ZMAC || r_state == ST_CMAC) begin
            mac_a     = (r_ph == 2'd0) ? {1'b0, wsel[WHALF_W-1:0]}
                                       : {1'b0, wsel[AREA_W-1:WHALF_W]};
            mac_b     = (r_state == ST_ZMAC) ? OP_W'(r_vz[r_k])
                                             : $signed({{(OP_W-COLOR_W){1'b0}}, csel});
            mac_first = (r_k == 2'd0) && (r_ph == 2'd0);
            mac_sub   = 1'b0;
            mac_hi    = (r_ph == 2'd1);
        end else begin
            mac_a     = {d_a[COORD_W], d_a};
            mac_b     = {d_b[COORD_W], d_b};
            mac_first = (r_ph == 2'd0);
            mac_sub   = (r_ph == 2'd1);
            mac_hi    = 1'b0;
        end
    end

    always_comb begin
        mac_prod = mac_a * mac_b;
        mac_term = mac_hi ? (ACC_W'(mac_prod) <<< WHALF_W) : ACC_W'(mac_prod);
        mac_sum  = (mac_first ? '0 : r_acc) + (mac_sub ? -mac_term : mac_term);
    end

    assign div_ge   = (r_rem >= r_dvs);
    assign div_diff = r_rem - r_dvs;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [10:0]       sx, sy;
        logic                     off;
        logic signed [ACC_W-1:0]  abs_acc;
        logic                     c_neg, c_pos, fail_now;
        logic [ACC_W-1:0]         s_u;
        logic [7:0]               cval;
        logic                     cdone;

        n_state     = r_state;
        n_k         = r_k;
        n_ph        = r_ph;
        n_col       = r_col;
        n_dcnt      = r_dcnt;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !o_res.ready;
        n_cov_fail  = r_cov_fail;
        n_vx = r_vx;  n_vy = r_vy;  n_vz = r_vz;
        n_cr = r_cr;  n_cg = r_cg;  n_cb = r_cb;
        n_area      = r_area;
        n_area_neg  = r_area_neg;
        n_px        = r_px;
        n_py        = r_py;
        n_addr      = r_addr;
        n_acc       = r_acc;
        n_w         = r_w;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_quo       = r_quo;
        n_zneg      = r_zneg;
        n_zq        = r_zq;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_drawn     = r_drawn;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = r_zq;

        sx       = {{3{i_req.data.pixel_x[7]}}, i_req.data.pixel_x};
        sy       = {{3{i_req.data.pixel_y[7]}}, i_req.data.pixel_y};
        off      = (sx <= -X_HALF) || (sx >= X_HALF) || (sy <= -Y_HALF) || (sy >= Y_HALF);
        abs_acc  = r_acc[ACC_W-1] ? -r_acc : r_acc;
        c_neg    = r_acc[ACC_W-1];
        c_pos    = !r_acc[ACC_W-1] && (r_acc != '0);
        fail_now = (c_neg && !r_area_neg) || (c_pos && r_area_neg);
        s_u      = r_acc;
        cval     = 8'hFF;
        cdone    = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = FAR_DEPTH;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req.data.req_type)
                        REQ_LOAD: begin
                            if (i_req.data.vertex_slot < 2'(NUM_VERT)) begin
                                n_vx[i_req.data.vertex_slot] = i_req.data.vert_x;
                                n_vy[i_req.data.vertex_slot] = i_req.data.vert_y;
                                n_vz[i_req.data.vertex_slot] = i_req.data.vert_z;
                                n_cr[i_req.data.vertex_slot] = i_req.data.vert_red;
                                n_cg[i_req.data.vertex_slot] = i_req.data.vert_green;
                                n_cb[i_req.data.vertex_slot] = i_req.data.vert_blue;
                                n_ph    = 2'd0;
                                n_state = ST_AREA;
                            end
                        end
                        REQ_SHADE: begin
                            n_px   = 16'($signed({{8{sx[7]}}, sx[7:0]})
                                         * $signed(16'(PX_SCALE)));
                            n_py   = 16'($signed({{8{sy[7]}}, sy[7:0]})
                                         * $signed(16'(PY_SCALE)));
                            n_addr = ADDR_W'((SCREEN_HEIGHT / 2 - int'(sy)) * SCREEN_WIDTH
                                             + int'(sx) + SCREEN_WIDTH / 2);
                            n_drawn = 1'b0;
                            if (off || (r_area == '0)) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_k        = 2'd0;
                                n_ph       = 2'd0;
                                n_cov_fail = 1'b0;
                                n_state    = ST_EDGE;
                            end
                        end
                        REQ_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_AREA: begin
                if (r_ph == 2'd2) begin
                    n_area     = abs_acc[AREA_W-1:0];
                    n_area_neg = r_acc[ACC_W-1];
                    n_state    = ST_IDLE;
                end else begin
                    n_acc = mac_sum;
                    n_ph  = r_ph + 2'd1;
                end
            end

            ST_EDGE: begin
                if (r_ph == 2'd2) begin
                    n_w[r_k]   = abs_acc[AREA_W-1:0];
                    n_cov_fail = r_cov_fail || fail_now;
                    n_ph       = 2'd0;
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_state = (r_cov_fail || fail_now) ? ST_EMIT : ST_ZMAC;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else begin
                    n_acc = mac_sum;
                    n_ph  = r_ph + 2'd1;
                end
            end

            ST_ZMAC, ST_CMAC: begin
                n_acc = mac_sum;
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if (r_k == 2'd2) begin
                        n_k     = 2'd0;
                        n_state = (r_state == ST_ZMAC) ? ST_ZCHK : ST_CCHK;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end

            ST_ZCHK: begin
                if (r_ph == 2'd0) begin
                    n_rem  = abs_acc;
                    n_zneg = r_acc[ACC_W-1];
                    n_dvs  = ACC_W'({r_area, {Z_SHIFT{1'b0}}});
                    n_ph   = 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if (r_rem > r_dvs) begin
                        n_state = ST_EMIT;   // depth magnitude above 1.0
                    end else begin
                        n_dcnt  = '0;
                        n_quo   = '0;
                        n_state = ST_ZDIV;
                    end
                end
            end

            ST_ZDIV: begin
                if (div_ge) begin
                    n_rem = div_diff;
                end
                n_quo  = {r_quo[ZDIV_N-2:0], div_ge};
                n_dvs  = r_dvs >> 1;
                n_dcnt = r_dcnt + 4'd1;
                if (r_dcnt == 4'(ZDIV_N - 1)) begin
                    n_state = ST_ZFIX;
                end
            end

            ST_ZFIX: begin
                n_zq    = r_zneg ? -ZQ_W'(r_quo) : ZQ_W'(r_quo);
                n_state = ST_ZCMP;
            end

            ST_ZCMP: begin
                if ($signed(ram_rdata) > r_zq) begin
                    ram_we  = 1'b1;
                    n_col   = 2'd0;
                    n_k     = 2'd0;
                    n_ph    = 2'd0;
                    n_state = ST_CMAC;
                end else begin
                    n_state = ST_EMIT;
                end
            end

            ST_CCHK: begin
                if (r_ph == 2'd0) begin
                    // floor(254 * s / 256), taken before the divide by area
                    n_rem = ((s_u << 8) - (s_u << 1)) >> C_SHIFT;
                    n_dvs = ACC_W'({r_area, {C_SHIFT{1'b0}}});
                    n_ph  = 2'd1;
                end else begin
                    n_ph = 2'd0;
                    if (div_ge) begin
                        cval  = 8'hFF;        // saturate above 255
                        cdone = 1'b1;
                    end else begin
                        n_dvs   = r_dvs >> 1;
                        n_dcnt  = '0;
                        n_quo   = '0;
                        n_state = ST_CDIV;
                    end
                end
            end

            ST_CDIV: begin
                if (div_ge) begin
                    n_rem = div_diff;
                end
                n_quo  = {r_quo[ZDIV_N-2:0], div_ge};
                n_dvs  = r_dvs >> 1;
                n_dcnt = r_dcnt + 4'd1;
                if (r_dcnt == 4'(CDIV_N - 1)) begin
                    cval  = {r_quo[CDIV_N-2:0], div_ge};
                    cdone = 1'b1;
                end
            end

            ST_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_drawn) begin
                        n_out.drawn      = 1'b1;
                        n_out.pix_red    = r_red;
                        n_out.pix_green  = r_green;
                        n_out.pix_blue   = r_blue;
                        n_out.frag_depth = r_zq[COORD_W-1:0];
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a color channel finished: store it, move on
        if (cdone) begin
            unique case (r_col)
                2'd0:    n_red   = cval;
                2'd1:    n_green = cval;
                default: n_blue  = cval;
            endcase
            if (r_col == 2'd2) begin
                n_drawn = 1'b1;
                n_state = ST_EMIT;
            end else begin
                n_col   = r_col + 2'd1;
                n_k     = 2'd0;
                n_ph    = 2'd0;
                n_state = ST_CMAC;
            end
        end
    end

    // control and triangle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_k         <= '0;
            r_ph        <= '0;
            r_col       <= '0;
            r_dcnt      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cov_fail  <= 1'b0;
            r_area      <= '0;
            r_area_neg  <= 1'b0;
            r_drawn     <= 1'b0;
            for (int i = 0; i < NUM_VERT; i++) begin
                r_vx[i] <= '0;
                r_vy[i] <= '0;
                r_vz[i] <= '0;
                r_cr[i] <= '0;
                r_cg[i] <= '0;
                r_cb[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_ph        <= n_ph;
            r_col       <= n_col;
            r_dcnt      <= n_dcnt;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_cov_fail  <= n_cov_fail;
            r_area      <= n_area;
            r_area_neg  <= n_area_neg;
            r_drawn     <= n_drawn;
            r_vx        <= n_vx;
            r_vy        <= n_vy;
            r_vz        <= n_vz;
            r_cr        <= n_cr;
            r_cg        <= n_cg;
            r_cb        <= n_cb;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_addr  <= n_addr;
        r_acc   <= n_acc;
        r_w     <= n_w;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_quo   <= n_quo;
        r_zneg  <= n_zneg;
        r_zq    <= n_zq;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
        r_out   <= n_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TZB_ASSERT(a_ram_write_src,
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_ZCMP),
        "depth store written outside clear or depth test")
    `TZB_ASSERT(a_div_bound,
        (r_state == ST_ZDIV || r_state == ST_CDIV) |-> (r_rem < {r_dvs, 1'b0}),
        "divider remainder out of range")
    `TZB_ASSERT_NEXT(a_emit_hold,
        r_state == ST_EMIT && r_out_valid && !o_res.ready, r_state == ST_EMIT,
        "result dropped while output stalled")

endmodule

`default_nettype wire

// ===== verif/tzb_shade_scoreboard.sv =====
// ----------------------------------------------------------------------------
// Shade result scoreboard
// Predicts fragment results of the triangle z-buffer shader from accepted
// requests and checks returned results against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import tzb_pkg::*;

class tzb_shade_scoreboard;

    // triangle state
    longint vx[3], vy[3], vz[3];
    longint vc[3][3];
    longint tri_area;
    int     zbuf[CELLS];

    t_res   pending[$];
    int     n_errors;
    int     n_drawn;
    int     n_results;

    function void reset_state();
        for (int i = 0; i < 3; i++) begin
            vx[i] = 0;
            vy[i] = 0;
            vz[i] = 0;
            for (int c = 0; c < 3; c++) vc[i][c] = 0;
        end
        tri_area = 0;
        clear_depth();
    endfunction

    function void clear_depth();
        for (int i = 0; i < CELLS; i++) zbuf[i] = 32768;
    endfunction

    function longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function longint edge_cross(longint ox, longint oy, longint qx, longint qy,
                                longint rx, longint ry);
        return (qx - ox) * (ry - oy) - (qy - oy) * (rx - ox);
    endfunction

    function int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // inclusive: point p on the same side of edge o-q as vertex t, or on it
    function bit on_inner_side(int o, int q, int t, longint px, longint py);
        longint dp, dt;
        dp = edge_cross(vx[o], vy[o], vx[q], vy[q], px, py);
        dt = edge_cross(vx[o], vy[o], vx[q], vy[q], vx[t], vy[t]);
        return sign_of(dp) * sign_of(dt) >= 0;
    endfunction

    function t_res shade_pixel(longint x, longint y);
        t_res   r;
        longint px, py, num, zq, s, v;
        longint w[3];
        int     addr;
        r = '0;
        if (x <= -(SCREEN_WIDTH / 2) || x >= SCREEN_WIDTH / 2 ||
            y <= -(SCREEN_HEIGHT / 2) || y >= SCREEN_HEIGHT / 2) return r;
        if (tri_area == 0) return r;
        px = (x * 32768) / SCREEN_WIDTH;
        py = (y * 32768) / SCREEN_HEIGHT;
        if (!on_inner_side(0, 1, 2, px, py) || !on_inner_side(1, 2, 0, px, py) ||
            !on_inner_side(2, 0, 1, px, py)) return r;
        w[0] = abs64(edge_cross(vx[1], vy[1], vx[2], vy[2], px, py));
        w[1] = abs64(edge_cross(vx[2], vy[2], vx[0], vy[0], px, py));
        w[2] = abs64(edge_cross(vx[0], vy[0], vx[1], vy[1], px, py));
        num = w[0] * vz[0] + w[1] * vz[1] + w[2] * vz[2];
        if (abs64(num) > tri_area * 16384) return r;
        zq = num / tri_area;      // SV division truncates toward zero
        addr = int'((SCREEN_HEIGHT / 2 - y) * SCREEN_WIDTH + (x + SCREEN_WIDTH / 2));
        if (!(zbuf[addr] > zq)) return r;
        zbuf[addr] = int'(zq);
        r.drawn = 1'b1;
        for (int c = 0; c < 3; c++) begin
            s = w[0] * vc[0][c] + w[1] * vc[1][c] + w[2] * vc[2][c];
            v = (s * 254) / (tri_area * 256);
            if (v > 255) v = 255;
            case (c)
                0: r.pix_red   = v[7:0];
                1: r.pix_green = v[7:0];
                default: r.pix_blue = v[7:0];
            endcase
        end
        r.frag_depth = zq[15:0];
        return r;
    endfunction

    function void note_request(t_req q);
        int s;
        case (q.req_type)
            REQ_LOAD: begin
                if (q.vertex_slot != 2'd3) begin
                    s = q.vertex_slot;
                    vx[s] = q.vert_x;
                    vy[s] = q.vert_y;
                    vz[s] = q.vert_z;
                    vc[s][0] = q.vert_red;
                    vc[s][1] = q.vert_green;
                    vc[s][2] = q.vert_blue;
                    tri_area = abs64(edge_cross(vx[0], vy[0], vx[1], vy[1],
                                                vx[2], vy[2]));
                end
            end
            REQ_SHADE: pending.push_back(shade_pixel(q.pixel_x, q.pixel_y));
            REQ_CLEAR: clear_depth();
            default: ;
        endcase
    endfunction

    function void check_result(t_res got);
        t_res exp;
        n_results++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            n_errors++;
            return;
        end
        exp = pending.pop_front();
        if (exp.drawn) n_drawn++;
        if (got.drawn !== exp.drawn)
            $display("%0t: drawn exp %0d got %0d", $time, exp.drawn, got.drawn);
        if (got.pix_red !== exp.pix_red)
            $display("%0t: red exp %0d got %0d", $time, exp.pix_red, got.pix_red);
        if (got.pix_green !== exp.pix_green)
            $display("%0t: green exp %0d got %0d", $time, exp.pix_green, got.pix_green);
        if (got.pix_blue !== exp.pix_blue)
            $display("%0t: blue exp %0d got %0d", $time, exp.pix_blue, got.pix_blue);
        if (got.frag_depth !== exp.frag_depth)
            $display("%0t: depth exp %0d got %0d", $time, exp.frag_depth,
                     got.frag_depth);
        if (got !== exp) n_errors++;
    endfunction
endclass

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Fragment shader testbench
// Drives vertex loads, pixel shades and depth clears through the request
// channel, predicts each shade result and checks it under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import tzb_pkg::*;

    localparam int IDLE_LIMIT = 400000;   // longer than a clear or the reset pass

    logic i_clk;
    logic i_rst_n;

    tzb_req_if req_ch ();
    tzb_res_if res_ch ();

    triangle_zbuffer_fragment_shader dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    tzb_shade_scoreboard shade_sb;

    int  send_idle_pct;   // chance in 100 that the sender idles instead of offering
    int  recv_stall_pct;  // chance in 100 that the receiver stalls
    bit  hold_off;        // long receiver hold-off in progress
    int  idle_cycles;
    int  n_requests;
    int  n_clears;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ready toggles at random; accepted results go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) shade_sb.check_result(res_ch.data);
        res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one request, with random gaps, and wait for acceptance;
    // valid stays up afterwards until the next call or release_channel
    task automatic send_request(t_req q);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= t_req'($urandom());
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        shade_sb.note_request(q);
        n_requests++;
        if (q.req_type == REQ_CLEAR) n_clears++;
    endtask

    // drop valid when no request follows right away
    task automatic release_channel();
        req_ch.valid <= 1'b0;
        req_ch.data  <= t_req'($urandom());
        @(posedge i_clk);
    endtask

    task automatic load_vertex(int slot, int x, int y, int z, int r, int g, int b);
        t_req q;
        q = t_req'({$urandom(), $urandom(), $urandom()});
        q.req_type    = REQ_LOAD;
        q.vertex_slot = slot[1:0];
        q.vert_x = x[15:0];
        q.vert_y = y[15:0];
        q.vert_z = z[15:0];
        q.vert_red = r[8:0];
        q.vert_green = g[8:0];
        q.vert_blue = b[8:0];
        send_request(q);
    endtask

    task automatic shade(int x, int y);
        t_req q;
        q = t_req'({$urandom(), $urandom(), $urandom()});
        q.req_type = REQ_SHADE;
        q.pixel_x = x[7:0];
        q.pixel_y = y[7:0];
        send_request(q);
    endtask

    task automatic plain_request(t_req_type kind);
        t_req q;
        q = t_req'({$urandom(), $urandom(), $urandom()});
        q.req_type = kind;
        send_request(q);
    endtask

    function automatic int rand_coord();
        return $urandom_range(32768) - 16384;
    endfunction

    function automatic int rand_color();
        // mostly in range, sometimes above 1.0 up to the full 9 bits
        return ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(256);
    endfunction

    // random triangle, sometimes degenerate or with out-of-range depth
    task automatic random_triangle();
        int x0, y0;
        x0 = rand_coord();
        y0 = rand_coord();
        for (int s = 0; s < 3; s++) begin
            if ($urandom_range(15) == 0)
                load_vertex(s, x0, y0, rand_coord(), rand_color(), rand_color(),
                            rand_color());
            else
                load_vertex(s, rand_coord(), rand_coord(),
                            ($urandom_range(3) == 0) ? $signed(16'($urandom()))
                                                      : rand_coord(),
                            rand_color(), rand_color(), rand_color());
        end
    endtask

    // mostly on-screen pixels, a few at the edges or off screen
    task automatic random_shades(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(15) == 0)
                shade($signed(8'($urandom())), $signed(8'($urandom())));
            else
                shade($urandom_range(254) - 127, $urandom_range(254) - 127);
        end
    endtask

    task automatic wait_drained();
        release_channel();
        while (shade_sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        shade_sb = new();
        shade_sb.reset_state();
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: shade before any load (degenerate), full-range triangle
        shade(0, 0);
        load_vertex(0, -16384, -16384, -16384, 0, 256, 511);
        load_vertex(1, 16384, -16384, 16384, 256, 0, 256);
        load_vertex(2, 0, 16384, 0, 511, 511, 0);
        load_vertex(3, 5, 5, 5, 1, 1, 1);                  // ignored slot
        shade(0, 0);
        shade(0, 0);                                       // same depth: not nearer
        shade(-127, -127);
        shade(127, 127);
        shade(-128, 0);                                    // off screen
        shade(0, -128);
        shade(-64, -127);                                  // on an edge corner region
        plain_request(REQ_NONE);
        plain_request(REQ_CLEAR);
        shade(0, 0);                                       // drawn again after clear
        load_vertex(2, 16384, 16384, 16384, 0, 0, 0);      // depth at the 1.0 limit
        load_vertex(0, -16384, 16384, 16384, 256, 256, 256);
        shade(64, 64);
        shade(100, 0);
        load_vertex(2, 0, 0, 0, 0, 0, 0);                  // collinear: zero area until the next load
        load_vertex(0, -16384, -16384, 0, 0, 0, 0);
        shade(10, 10);
        wait_drained();

        // random phases with the four idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 18 : 0;
            recv_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 18 : 0;
            for (int t = 0; t < 12; t++) begin
                random_triangle();
                random_shades(16);
                if ($urandom_range(3) == 0) plain_request(REQ_NONE);
            end
            if (ph == 1) plain_request(REQ_CLEAR);
        end

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                random_triangle();
                random_shades(20);
                release_channel();
            end
        join

        wait_drained();
        $display("Covered %0d requests, %0d clears, %0d results, %0d drawn.",
                 n_requests, n_clears, shade_sb.n_results, shade_sb.n_drawn);
        $display("Phases: no idling, sender idle, receiver stall, both, long hold-off.");
        if (shade_sb.n_errors == 0 && shade_sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tzb_pkg.sv
hw/rtl/tzb_if.sv
hw/rtl/tzb_ram.sv
hw/rtl/triangle_zbuffer_fragment_shader.sv
verif/tzb_shade_scoreboard.sv
verif/testbench.sv
